// ----- rtl/fbc_pkg.sv -----
`default_nettype none

package fbc_pkg;

    // Field widths of the channels and the configuration register.
    localparam int unsigned KIND_WIDTH  = 2;
    localparam int unsigned CHAN_WIDTH  = 8;
    localparam int unsigned ALPHA_WIDTH = 17;

    // The global alpha register is Q16. It is padded on the right
    // before rescaling so that any opacity fraction width up to 40 bits works.
    localparam int unsigned ALPHA_FRAC = 16;
    localparam int unsigned ALPHA_PAD  = 24;

    localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE   = 17'h10000;
    localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET = ALPHA_ONE;

    // Layer sample kinds.
    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_GRAY   = 2'd0,
        KIND_RGB    = 2'd1,
        KIND_RGBA   = 2'd2,
        KIND_ABSENT = 2'd3
    } t_layer_kind;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WEIGHT,
        ST_ACCUM
    } t_fbc_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic calc_weight;
        logic accum;
        logic emit;
    } t_fbc_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_layer;
        logic out_stall;
    } t_fbc_stat;

endpackage

`default_nettype wire

// ----- rtl/fbc_layer_if.sv -----
`default_nettype none

interface fbc_layer_if;

    logic                            valid;
    logic                            ready;
    logic [fbc_pkg::KIND_WIDTH-1:0]  layer_kind;
    logic [fbc_pkg::CHAN_WIDTH-1:0]  red_or_gray;
    logic [fbc_pkg::CHAN_WIDTH-1:0]  green;
    logic [fbc_pkg::CHAN_WIDTH-1:0]  blue;
    logic [fbc_pkg::CHAN_WIDTH-1:0]  layer_alpha;
    logic                            last_layer;

    modport source (
        output valid, layer_kind, red_or_gray, green, blue, layer_alpha, last_layer,
        input  ready
    );

    modport sink (
        input  valid, layer_kind, red_or_gray, green, blue, layer_alpha, last_layer,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/fbc_pixel_if.sv -----
`default_nettype none

interface fbc_pixel_if;

    logic                            valid;
    logic                            ready;
    logic [fbc_pkg::CHAN_WIDTH-1:0]  out_red;
    logic [fbc_pkg::CHAN_WIDTH-1:0]  out_green;
    logic [fbc_pkg::CHAN_WIDTH-1:0]  out_blue;

    modport source (
        output valid, out_red, out_green, out_blue,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/front_to_back_layer_compositor_top.sv -----
// Front-to-back layer compositor against a black backdrop.
//
// i_layer carries one word per layer sample of the current pixel, top layer
// first; the word marked last_layer closes the pixel. o_pixel carries one
// word per pixel with the composited red, green and blue. Both channels
// use valid/ready; a word moves when both are high at a clock edge.
// i_cfg_we/i_cfg_wdata write the Q16 global alpha; write it only while idle.
//
// Each layer word passes three steps: accept, where the layer opacity is
// formed; weight, which multiplies it by the unused opacity; and accumulate,
// for the channel multiplies and the sum update. The weight feeds the opacity
// accumulator that the next word needs, so a word is taken only after the
// previous one's accumulate step; a last layer's step fills the output register.
//
// The output register holds one finished pixel, so further layers are taken
// while the receiver stalls; only the next last layer waits in the
// accumulate step until the held pixel is taken.
// Reset (synchronous, active low) clears the sums and the used opacity,
// empties the output register and sets the global alpha to full opacity.

`default_nettype none

module front_to_back_layer_compositor_top #(
    parameter int unsigned OPACITY_FRAC_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [fbc_pkg::ALPHA_WIDTH-1:0]  i_cfg_wdata,
    fbc_layer_if.sink                             i_layer,
    fbc_pixel_if.source                           o_pixel
);

    fbc_pkg::t_fbc_cmd  w_cmd;
    fbc_pkg::t_fbc_stat w_stat;

    // Sequencer.
    fbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_layer.valid),
        .o_in_ready (i_layer.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Opacity, weight and sum datapath.
    fbc_dpath #(
        .OPACITY_FRAC_BITS (OPACITY_FRAC_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_layer_kind  (i_layer.layer_kind),
        .i_red_or_gray (i_layer.red_or_gray),
        .i_green       (i_layer.green),
        .i_blue        (i_layer.blue),
        .i_layer_alpha (i_layer.layer_alpha),
        .i_last_layer  (i_layer.last_layer),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_valid   (o_pixel.valid),
        .i_out_ready   (o_pixel.ready),
        .o_out_red     (o_pixel.out_red),
        .o_out_green   (o_pixel.out_green),
        .o_out_blue    (o_pixel.out_blue)
    );

endmodule

`default_nettype wire

// ----- rtl/fbc_ctrl.sv -----
`default_nettype none

module fbc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  fbc_pkg::t_fbc_stat      i_stat,
    output fbc_pkg::t_fbc_cmd       o_cmd
);

    fbc_pkg::t_fbc_state r_state;
    fbc_pkg::t_fbc_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands. A word is taken only in the idle state; the
    // weight and the accumulate steps follow it in that order. A last
    // layer waits in the accumulate step while the output register is full
    // and its word is not being taken.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            fbc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = fbc_pkg::ST_WEIGHT;
                end
            end
            fbc_pkg::ST_WEIGHT: begin
                o_cmd.calc_weight = 1'b1;
                n_state           = fbc_pkg::ST_ACCUM;
            end
            fbc_pkg::ST_ACCUM: begin
                if (!i_stat.last_layer) begin
                    o_cmd.accum = 1'b1;
                    n_state     = fbc_pkg::ST_IDLE;
                end else if (!i_stat.out_stall) begin
                    o_cmd.accum = 1'b1;
                    o_cmd.emit  = 1'b1;
                    n_state     = fbc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fbc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/fbc_dpath.sv -----
`default_nettype none

module fbc_dpath #(
    parameter int unsigned OPACITY_FRAC_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fbc_pkg::ALPHA_WIDTH-1:0]   i_cfg_wdata,
    input  wire logic [fbc_pkg::KIND_WIDTH-1:0]    i_layer_kind,
    input  wire logic [fbc_pkg::CHAN_WIDTH-1:0]    i_red_or_gray,
    input  wire logic [fbc_pkg::CHAN_WIDTH-1:0]    i_green,
    input  wire logic [fbc_pkg::CHAN_WIDTH-1:0]    i_blue,
    input  wire logic [fbc_pkg::CHAN_WIDTH-1:0]    i_layer_alpha,
    input  wire logic                              i_last_layer,
    input  fbc_pkg::t_fbc_cmd                      i_cmd,
    output fbc_pkg::t_fbc_stat                     o_stat,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [fbc_pkg::CHAN_WIDTH-1:0]         o_out_red,
    output logic [fbc_pkg::CHAN_WIDTH-1:0]         o_out_green,
    output logic [fbc_pkg::CHAN_WIDTH-1:0]         o_out_blue
);

    localparam int unsigned F   = OPACITY_FRAC_BITS;
    localparam int unsigned OW  = F + 1;
    localparam int unsigned CW  = fbc_pkg::CHAN_WIDTH;
    localparam int unsigned AW  = fbc_pkg::ALPHA_WIDTH;
    localparam int unsigned GW  = AW + fbc_pkg::ALPHA_PAD;
    localparam int unsigned GA_SHIFT = fbc_pkg::ALPHA_FRAC + fbc_pkg::ALPHA_PAD - F;
    // Reciprocal of 255 for floor(alpha * ONE / 255): exact for all 8-bit alphas.
    localparam int unsigned RSHIFT = 16;
    localparam int unsigned RW     = F + 9;
    localparam int unsigned PW     = RW + CW;

    localparam logic [OW-1:0] ONE    = {1'b1, {F{1'b0}}};
    localparam logic [OW-1:0] THRESH = OW'((64'(ONE) * 64'd95) / 64'd100);
    localparam logic [RW-1:0] RECIP  =
        RW'(((64'd1 << (F + RSHIFT)) + 64'd254) / 64'd255);

    // Configuration and accumulator state.
    logic [AW-1:0] r_galpha;
    logic [OW-1:0] r_used;
    logic [CW-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic          r_out_valid;

    // Item and weight registers.
    logic [OW-1:0] r_layer_op;
    logic          r_counts;
    logic          r_last;
    logic [CW-1:0] r_ch_r, r_ch_g, r_ch_b;
    logic [OW-1:0] r_weight;
    logic          r_en;
    logic [CW-1:0] r_out_r, r_out_g, r_out_b;

    // Layer opacity of the incoming word.
    logic [GW-1:0]      w_ga_wide;
    logic [OW-1:0]      w_ga_qf;
    logic [PW-1:0]      w_rgba_prod;
    logic [OW-1:0]      w_rgba_op;
    logic [OW-1:0]      w_layer_op;
    logic               w_counts;
    logic [CW-1:0]      w_ch_g, w_ch_b;

    assign w_ga_wide   = {r_galpha, {fbc_pkg::ALPHA_PAD{1'b0}}} >> GA_SHIFT;
    assign w_ga_qf     = (r_galpha == '0 || r_galpha > fbc_pkg::ALPHA_ONE) ?
                         ONE : w_ga_wide[OW-1:0];
    assign w_rgba_prod = PW'(i_layer_alpha) * PW'(RECIP);
    assign w_rgba_op   = w_rgba_prod[RSHIFT +: OW];

    // Decode the kind: opacity, and whether it counts (present, no zero channel).
    always_comb begin
        w_layer_op = '0;
        w_counts   = 1'b0;
        w_ch_g     = i_green;
        w_ch_b     = i_blue;
        unique case (fbc_pkg::t_layer_kind'(i_layer_kind))
            fbc_pkg::KIND_GRAY: begin
                w_layer_op = w_ga_qf;
                w_counts   = (i_red_or_gray != '0);
                w_ch_g     = i_red_or_gray;
                w_ch_b     = i_red_or_gray;
            end
            fbc_pkg::KIND_RGB: begin
                w_layer_op = w_ga_qf;
                w_counts   = (i_red_or_gray != '0) && (i_green != '0) && (i_blue != '0);
            end
            fbc_pkg::KIND_RGBA: begin
                w_layer_op = w_rgba_op;
                w_counts   = (i_red_or_gray != '0) && (i_green != '0) && (i_blue != '0);
            end
            fbc_pkg::KIND_ABSENT: begin
                w_counts = 1'b0;
            end
            default: begin
                w_counts = 1'b0;
            end
        endcase
    end

    // Weight: layer opacity times the unused opacity.
    logic [OW-1:0]   w_used;
    logic [OW-1:0]   w_rem;
    logic [2*OW-1:0] w_wprod;
    logic [OW-1:0]   w_weight;
    logic            w_en;

    assign w_used   = (r_used > ONE) ? ONE : r_used;
    assign w_rem    = ONE - w_used;
    assign w_wprod  = (2*OW)'(r_layer_op) * (2*OW)'(w_rem);
    assign w_weight = w_wprod[F +: OW];
    assign w_en     = r_counts && (w_used < THRESH);

    // Channel terms and the next sums, modulo 256.
    logic [OW+CW-1:0] w_prod_r, w_prod_g, w_prod_b;
    logic [CW-1:0]    w_next_r, w_next_g, w_next_b;

    assign w_prod_r = (OW+CW)'(r_weight) * (OW+CW)'(r_ch_r);
    assign w_prod_g = (OW+CW)'(r_weight) * (OW+CW)'(r_ch_g);
    assign w_prod_b = (OW+CW)'(r_weight) * (OW+CW)'(r_ch_b);
    assign w_next_r = r_sum_r + (r_en ? w_prod_r[F +: CW] : CW'(0));
    assign w_next_g = r_sum_g + (r_en ? w_prod_g[F +: CW] : CW'(0));
    assign w_next_b = r_sum_b + (r_en ? w_prod_b[F +: CW] : CW'(0));

    // Register, accumulators and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_galpha    <= fbc_pkg::ALPHA_RESET;
            r_used      <= '0;
            r_sum_r     <= '0;
            r_sum_g     <= '0;
            r_sum_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_galpha <= i_cfg_wdata;
            end
            if (i_cmd.calc_weight && w_en) begin
                r_used <= w_used + w_weight;
            end
            if (i_cmd.accum) begin
                if (i_cmd.emit) begin
                    r_used  <= '0;
                    r_sum_r <= '0;
                    r_sum_g <= '0;
                    r_sum_b <= '0;
                end else begin
                    r_sum_r <= w_next_r;
                    r_sum_g <= w_next_g;
                    r_sum_b <= w_next_b;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_layer_op <= w_layer_op;
            r_counts   <= w_counts;
            r_last     <= i_last_layer;
            r_ch_r     <= i_red_or_gray;
            r_ch_g     <= w_ch_g;
            r_ch_b     <= w_ch_b;
        end
        if (i_cmd.calc_weight) begin
            r_weight <= w_weight;
            r_en     <= w_en;
        end
        if (i_cmd.emit) begin
            r_out_r <= w_next_r;
            r_out_g <= w_next_g;
            r_out_b <= w_next_b;
        end
    end

    assign o_stat.last_layer = r_last;
    assign o_stat.out_stall  = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_red         = r_out_r;
    assign o_out_green       = r_out_g;
    assign o_out_blue        = r_out_b;

endmodule

`default_nettype wire

// ----- rtl/fbc_checker.sv -----
`default_nettype none

module fbc_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             i_in_ready,
    input wire logic                             i_in_last,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [fbc_pkg::CHAN_WIDTH-1:0]   i_out_red,
    input wire logic [fbc_pkg::CHAN_WIDTH-1:0]   i_out_green,
    input wire logic [fbc_pkg::CHAN_WIDTH-1:0]   i_out_blue
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("pixel word valid right after reset");

    // A stalled pixel word stays and holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_red) && $stable(i_out_green) &&
            $stable(i_out_blue))
        else $error("stalled pixel word changed");

    // After a layer word is taken, the weight and accumulate steps block input.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready ##1 !i_in_ready)
        else $error("layer word taken during weight or accumulate step");

    // A pixel word that appears in an empty output register comes from a last
    // layer that passed the weight and accumulate steps without waiting.
    a_emit_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_in_acc && i_in_last, 3))
        else $error("pixel word without a last layer");

endmodule

bind front_to_back_layer_compositor_top fbc_checker u_fbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_layer.valid),
    .i_in_ready  (i_layer.ready),
    .i_in_last   (i_layer.last_layer),
    .i_out_valid (o_pixel.valid),
    .i_out_ready (o_pixel.ready),
    .i_out_red   (o_pixel.out_red),
    .i_out_green (o_pixel.out_green),
    .i_out_blue  (o_pixel.out_blue)
);

`default_nettype wire
